### hw/rtl/vgf_pkg.sv
// vgf_pkg: shared constants, register indexes and interface structs for the
// vertical gradient fill engine; no dependencies
`default_nettype none

package vgf_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);   // width/height fields
    localparam int POS_W         = $clog2(MAX_DIMENSION);       // x/y counters
    localparam int PITCH_W       = 15;
    localparam int STRIDE_W      = PITCH_W - 2;
    localparam int OFFSET_W      = POS_W + STRIDE_W;
    localparam int BASE_W        = 48;
    localparam int ADDR_W        = 49;
    localparam int RGB_W         = 24;
    localparam int PIXEL_W       = 32;
    localparam int CFG_INDEX_W   = 3;
    localparam int OUT_DATA_W    = 88;                          // 49 + 32, padded to bytes
    localparam int IN_DATA_W     = 8;

    localparam logic [7:0]       ALPHA_OPAQUE     = 8'hFF;
    localparam logic [RGB_W-1:0] TOP_COLOR_RESET  = 24'h5FD4C4;
    localparam logic [RGB_W-1:0] BOT_COLOR_RESET  = 24'h0D7D77;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_BYTES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_COLOR    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_COLOR = 3'd5;

    // request to the per-row unit; colors and height must hold while it runs
    typedef struct packed {
        logic                start;
        logic [POS_W-1:0]    row;
        logic [DIM_W-1:0]    height;
        logic [STRIDE_W-1:0] stride;
        logic [RGB_W-1:0]    top_color;
        logic [RGB_W-1:0]    bottom_color;
    } row_req_t;

    typedef struct packed {
        logic                done;
        logic [RGB_W-1:0]    color;
        logic [OFFSET_W-1:0] offset;
    } row_res_t;

endpackage

`default_nettype wire

### hw/rtl/vgf_row_unit.sv
// vgf_row_unit: per-row setup sequencer (gradient step divide, channel blend,
// row offset multiply); depends on vgf_pkg
`default_nettype none

module vgf_row_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vgf_pkg::row_req_t req,
    output vgf_pkg::row_res_t  res
);

    localparam logic [1:0] RU_IDLE  = 2'd0;
    localparam logic [1:0] RU_DIV   = 2'd1;
    localparam logic [1:0] RU_BLEND = 2'd2;
    localparam logic [1:0] RU_OFS   = 2'd3;

    localparam int NUM_W = vgf_pkg::POS_W + 8;

    logic [1:0]                   state_reg, state_next;
    logic [2:0]                   step_reg;
    logic [NUM_W-1:0]             rem_reg;
    logic [NUM_W-1:0]             div_reg;
    logic [7:0]                   t_reg;
    logic [vgf_pkg::POS_W-1:0]    row_reg;
    logic [vgf_pkg::STRIDE_W-1:0] stride_reg;
    logic [vgf_pkg::RGB_W-1:0]    color_reg;
    logic [vgf_pkg::OFFSET_W-1:0] offset_reg;
    logic                         done_reg;

    logic [7:0]  chan_a, chan_b;
    logic [8:0]  t_inv;
    logic [16:0] blend_sum;
    logic        fits;

    // one restoring step: quotient is below 256 since row < height
    assign fits = rem_reg >= div_reg;

    always_comb
    begin
        chan_a = req.top_color[7:0];
        chan_b = req.bottom_color[7:0];
        case (step_reg[1:0])
            2'd0:
            begin
                chan_a = req.top_color[7:0];
                chan_b = req.bottom_color[7:0];
            end
            2'd1:
            begin
                chan_a = req.top_color[15:8];
                chan_b = req.bottom_color[15:8];
            end
            default:
            begin
                chan_a = req.top_color[23:16];
                chan_b = req.bottom_color[23:16];
            end
        endcase
        t_inv     = 9'd256 - {1'b0, t_reg};
        blend_sum = 17'(chan_a) * 17'(t_inv) + 17'(chan_b) * 17'({1'b0, t_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            RU_IDLE:  if (req.start) state_next = RU_DIV;
            RU_DIV:   if (step_reg == 3'd0) state_next = RU_BLEND;
            RU_BLEND: if (step_reg == 3'd2) state_next = RU_OFS;
            RU_OFS:   state_next = RU_IDLE;
            default:  state_next = RU_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == RU_OFS);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            RU_IDLE:
            begin
                if (req.start)
                begin
                    rem_reg    <= {req.row, 8'd0};
                    div_reg    <= NUM_W'({req.height, 7'd0});
                    row_reg    <= req.row;
                    stride_reg <= req.stride;
                    step_reg   <= 3'd7;
                    t_reg      <= 8'd0;
                end
            end
            RU_DIV:
            begin
                if (fits)
                    rem_reg <= rem_reg - div_reg;
                div_reg  <= div_reg >> 1;
                t_reg    <= {t_reg[6:0], fits};
                step_reg <= (step_reg == 3'd0) ? 3'd0 : step_reg - 3'd1;
            end
            RU_BLEND:
            begin
                case (step_reg[1:0])
                    2'd0:    color_reg[7:0]   <= blend_sum[15:8];
                    2'd1:    color_reg[15:8]  <= blend_sum[15:8];
                    default: color_reg[23:16] <= blend_sum[15:8];
                endcase
                step_reg <= step_reg + 3'd1;
            end
            RU_OFS:
            begin
                offset_reg <= vgf_pkg::OFFSET_W'(row_reg) * vgf_pkg::OFFSET_W'(stride_reg);
            end
            default:
            begin
                step_reg <= 3'd0;
            end
        endcase
    end

    assign res.done   = done_reg;
    assign res.color  = color_reg;
    assign res.offset = offset_reg;

endmodule

`default_nettype wire

### hw/rtl/vertical_gradient_fill.sv
// vertical_gradient_fill: top level of the gradient fill engine, holds the
// registers, pixel walker and output register; depends on vgf_pkg, vgf_row_unit
//
// usage
//   the input stream carries one tick word per pixel; tdata bit 0 is restart
//   (1 starts a new frame at pixel 0,0, 0 advances one pixel). each accepted
//   tick yields zero or one pixel write word on the output stream: tdata holds
//   the byte address (bits 48:0) and the ARGB8888 color (bits 80:49), tlast
//   marks the final pixel of the frame. ticks while idle or after the last
//   pixel produce nothing. the user writes registers through cfg_we/cfg_index/
//   cfg_wdata only while the engine is idle; the block does not enforce this;
//   base, width and height are read live at each tick, pitch at row setup.
// timing
//   a pixel inside a row appears in the cycle after its tick is accepted, and a
//   tick is taken every cycle while no row setup runs and the output is free
//   or being drained. the tick that ends a row before the last runs the row
//   setup sequencer first: 8 divide steps, 3 channel blends and one offset
//   multiply; that pixel appears after the multiply and no tick is taken
//   meanwhile, so each row before the last adds the setup to the frame time.
// reset and stall
//   reset clears the walker to idle and loads the register reset values;
//   a stalled output holds its word and blocks further ticks until taken.
`default_nettype none

module vertical_gradient_fill (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // tick input, tdata: restart
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [vgf_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // pixel write output, tdata: write_address, pixel_color
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [vgf_pkg::OUT_DATA_W-1:0]            m_axis_tdata,
    output logic                                      m_axis_tlast,
    // register write port
    input  wire logic                                 cfg_we,
    input  wire logic [vgf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [vgf_pkg::BASE_W-1:0]           cfg_wdata
);

    localparam logic ST_IDLE = 1'b0;   // taking ticks
    localparam logic ST_ROW  = 1'b1;   // waiting on row setup

    localparam int POS_W = vgf_pkg::POS_W;
    localparam int DIM_W = vgf_pkg::DIM_W;

    // configuration registers
    logic [vgf_pkg::BASE_W-1:0]  base_reg;
    logic [DIM_W-1:0]            width_reg;
    logic [DIM_W-1:0]            height_reg;
    logic [vgf_pkg::PITCH_W-1:0] pitch_reg;
    logic [vgf_pkg::RGB_W-1:0]   top_reg;
    logic [vgf_pkg::RGB_W-1:0]   bottom_reg;

    // walker state
    logic                         state_reg;
    logic [POS_W-1:0]             col_reg;
    logic [POS_W-1:0]             row_reg;
    logic [vgf_pkg::OFFSET_W-1:0] offset_reg;
    logic [vgf_pkg::RGB_W-1:0]    color_reg;
    logic                         active_reg;

    // output register
    logic                         out_valid_reg;
    logic [vgf_pkg::ADDR_W-1:0]   out_addr_reg;
    logic [vgf_pkg::PIXEL_W-1:0]  out_pixel_reg;
    logic                         out_last_reg;

    logic                         in_acc, out_acc;
    logic                         restart;
    logic                         enabled;
    logic [DIM_W-1:0]             eff_w, eff_h;
    logic [POS_W-1:0]             cur_col, cur_row;
    logic [vgf_pkg::OFFSET_W-1:0] cur_offset;
    logic [vgf_pkg::RGB_W-1:0]    cur_color;
    logic                         cur_active;
    logic                         emit;
    logic                         row_end, col_end, last;
    logic                         row_start;
    logic [DIM_W-1:0]             col_plus, row_plus;
    logic [vgf_pkg::OFFSET_W:0]   pix_index;
    logic [vgf_pkg::ADDR_W-1:0]   pix_addr;

    vgf_pkg::row_req_t row_req;
    vgf_pkg::row_res_t row_res;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign restart = s_axis_tdata[0];

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);

    // oversized dimensions clamp to the maximum
    assign eff_w = (width_reg > DIM_W'(vgf_pkg::MAX_DIMENSION)) ?
                   DIM_W'(vgf_pkg::MAX_DIMENSION) : width_reg;
    assign eff_h = (height_reg > DIM_W'(vgf_pkg::MAX_DIMENSION)) ?
                   DIM_W'(vgf_pkg::MAX_DIMENSION) : height_reg;
    assign enabled = (base_reg != '0) && (width_reg != '0) && (height_reg != '0);

    // a restart starts row 0: blend weight zero, so top color and offset zero
    assign cur_col    = restart ? '0 : col_reg;
    assign cur_row    = restart ? '0 : row_reg;
    assign cur_offset = restart ? '0 : offset_reg;
    assign cur_color  = restart ? top_reg : color_reg;
    assign cur_active = restart ? enabled : active_reg;

    assign emit = cur_active && enabled &&
                  ({1'b0, cur_col} < eff_w) && ({1'b0, cur_row} < eff_h);

    assign col_plus  = {1'b0, cur_col} + DIM_W'(1);
    assign row_plus  = {1'b0, cur_row} + DIM_W'(1);
    assign col_end   = col_plus >= eff_w;
    assign row_end   = row_plus >= eff_h;
    assign last      = col_end && row_end;
    assign row_start = in_acc && emit && col_end && !row_end;

    assign pix_index = {1'b0, cur_offset} + (vgf_pkg::OFFSET_W + 1)'(cur_col);
    assign pix_addr  = vgf_pkg::ADDR_W'(base_reg) + vgf_pkg::ADDR_W'({pix_index, 2'b00});

    assign row_req.start        = row_start;
    assign row_req.row          = row_plus[POS_W-1:0];
    assign row_req.height       = eff_h;
    assign row_req.stride       = pitch_reg[vgf_pkg::PITCH_W-1:2];
    assign row_req.top_color    = top_reg;
    assign row_req.bottom_color = bottom_reg;

    vgf_row_unit u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (row_req),
        .res   (row_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            pitch_reg     <= '0;
            top_reg       <= vgf_pkg::TOP_COLOR_RESET;
            bottom_reg    <= vgf_pkg::BOT_COLOR_RESET;
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            offset_reg    <= '0;
            color_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vgf_pkg::REG_BASE_ADDRESS: base_reg   <= cfg_wdata;
                    vgf_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                    vgf_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                    vgf_pkg::REG_PITCH_BYTES:  pitch_reg  <= cfg_wdata[vgf_pkg::PITCH_W-1:0];
                    vgf_pkg::REG_TOP_COLOR:    top_reg    <= cfg_wdata[vgf_pkg::RGB_W-1:0];
                    vgf_pkg::REG_BOTTOM_COLOR: bottom_reg <= cfg_wdata[vgf_pkg::RGB_W-1:0];
                    default: ;
                endcase
            end

            // a new word goes out at once, except one ending a row before the last waits on setup
            if (row_res.done || (in_acc && emit && !row_start))
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;

            if (in_acc)
            begin
                if (!emit)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    if (restart)
                    begin
                        offset_reg <= '0;
                        color_reg  <= top_reg;
                    end
                    if (last)
                    begin
                        active_reg <= 1'b0;
                    end
                    else if (!col_end)
                    begin
                        active_reg <= 1'b1;
                        col_reg    <= col_plus[POS_W-1:0];
                        row_reg    <= cur_row;
                    end
                    else
                    begin
                        // word is held back until the next row is set up
                        active_reg <= 1'b1;
                        col_reg    <= '0;
                        row_reg    <= row_plus[POS_W-1:0];
                        state_reg  <= ST_ROW;
                    end
                end
            end

            if (row_res.done)
            begin
                color_reg     <= row_res.color;
                offset_reg    <= row_res.offset;
                state_reg     <= ST_IDLE;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_acc && emit)
        begin
            out_addr_reg  <= pix_addr;
            out_pixel_reg <= {vgf_pkg::ALPHA_OPAQUE, cur_color};
            out_last_reg  <= last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = vgf_pkg::OUT_DATA_W'({out_pixel_reg, out_addr_reg});
    assign m_axis_tlast  = out_last_reg;

    // row setup only completes while the walker waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        row_res.done |-> state_reg == ST_ROW)
        else $error("row setup done outside row wait");

    // a tick ending a row before the last always parks the walker until setup is done
    assert property (@(posedge clk) disable iff (!rst_n)
        row_start |=> state_reg == ST_ROW && !m_axis_tvalid)
        else $error("row start did not enter row wait");

    // once the final pixel is out the frame is no longer active
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !active_reg)
        else $error("frame still active after last pixel");

endmodule

`default_nettype wire

### tb/testbench.sv
// testbench: self-checking regression for the vertical gradient fill engine,
// a pixel walk predictor checks every output word; depends on vgf_pkg and vertical_gradient_fill
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import vgf_pkg::*;

    // one expected pixel write: address, color and the tlast flag
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] color;
        logic               last;
    } pixel_write_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;    // bit 0: restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;    // write_address, pixel_color
    logic                   m_axis_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BASE_W-1:0]      cfg_wdata;

    vertical_gradient_fill dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // register copies as the engine should see them
    logic [BASE_W-1:0]   base_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [PITCH_W-1:0]  pitch_reg;
    logic [RGB_W-1:0]    top_reg;
    logic [RGB_W-1:0]    bottom_reg;

    // pixel walker state of the predictor
    int unsigned         walk_col;
    int unsigned         walk_row;
    logic [63:0]         walk_offset;
    logic [RGB_W-1:0]    walk_rgb;
    bit                  walk_active;

    pixel_write_t        pending_writes[$];   // pixel writes still to come out
    bit                  tick_queue[$];       // restart bits waiting for the driver

    int unsigned         ticks_issued;
    int unsigned         ticks_accepted;
    int unsigned         words_checked;
    int unsigned         mismatches;
    int unsigned         tick_gap;
    int unsigned         ready_stall;
    int unsigned         hold_left;
    bit                  tick_taken;
    bit                  word_taken;
    bit                  calm;                // no idling on either side while set

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIMENSION) ? MAX_DIMENSION : int'(v);
    endfunction

    // blend colour and row offset for row y, done once per row start
    function automatic void latch_row(input int unsigned y, input int unsigned h);
        int unsigned t;
        int unsigned a;
        int unsigned b;
        t = (y * 256) / h;
        for (int ch = 0; ch < 3; ch++)
        begin
            a = (top_reg >> (8 * ch)) & 8'hFF;
            b = (bottom_reg >> (8 * ch)) & 8'hFF;
            walk_rgb[8 * ch +: 8] = 8'((a * (256 - t) + b * t) / 256);
        end
        walk_offset = 64'(y) * 64'(pitch_reg >> 2);
    endfunction

    // one accepted tick: advance the walk and queue the pixel write it causes
    function automatic void fill_step(input bit restart);
        int unsigned  w;
        int unsigned  h;
        bit           enabled;
        bit           last;
        logic [63:0]  full_addr;
        pixel_write_t pw;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        enabled = (base_reg != 0) && (width_reg != 0) && (height_reg != 0);
        if (restart)
        begin
            walk_active = 1'b0;
            if (!enabled)
                return;
            walk_col = 0;
            walk_row = 0;
            latch_row(0, h);
            walk_active = 1'b1;
        end
        if (!walk_active)
            return;
        // live registers may have moved the rectangle under the walker
        if (!enabled || walk_col >= w || walk_row >= h)
        begin
            walk_active = 1'b0;
            return;
        end
        full_addr = 64'(base_reg) + 64'd4 * (walk_offset + 64'(walk_col));
        last = (walk_col + 1 >= w) && (walk_row + 1 >= h);
        pw.addr = full_addr[ADDR_W-1:0];
        pw.color = {ALPHA_OPAQUE, walk_rgb};
        pw.last = last;
        pending_writes.push_back(pw);
        if (last)
            walk_active = 1'b0;
        else if (walk_col + 1 < w)
            walk_col++;
        else
        begin
            walk_col = 0;
            walk_row++;
            latch_row(walk_row, h);
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // clock, reset, watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BASE_ADDRESS;
        cfg_wdata = '0;
        forever #1 clk = ~clk;
    end

    // generous bound, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("vertical_gradient_fill regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // sampling at the rising edge: handshakes, checks, prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        pixel_write_t want;
        tick_taken = rst_n && s_axis_tvalid && s_axis_tready;
        word_taken = rst_n && m_axis_tvalid && m_axis_tready;
        // a word always belongs to an earlier tick, so check before predicting
        if (word_taken)
        begin
            words_checked++;
            if (pending_writes.size() == 0)
                flag_mismatch("unexpected word, address", 64'(m_axis_tdata[ADDR_W-1:0]), 0);
            else
            begin
                want = pending_writes.pop_front();
                if (m_axis_tdata[ADDR_W-1:0] !== want.addr)
                    flag_mismatch("write_address", 64'(m_axis_tdata[ADDR_W-1:0]),
                                  64'(want.addr));
                if (m_axis_tdata[ADDR_W +: PIXEL_W] !== want.color)
                    flag_mismatch("pixel_color", 64'(m_axis_tdata[ADDR_W +: PIXEL_W]),
                                  64'(want.color));
                if (m_axis_tlast !== want.last)
                    flag_mismatch("frame_last", 64'(m_axis_tlast), 64'(want.last));
            end
        end
        if (tick_taken)
        begin
            ticks_accepted++;
            fill_step(s_axis_tdata[0]);
        end
    end

    // ------------------------------------------------------------------
    // tick driver, changes inputs on the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || tick_taken))
        begin
            if (tick_gap > 0)
            begin
                tick_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (tick_queue.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= IN_DATA_W'(tick_queue.pop_front());
                tick_gap = calm ? 0 : $urandom_range(0, 6);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output receiver: random stall per word, plus one long hold-off
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (word_taken)
        begin
            ready_stall = calm ? 0 : $urandom_range(0, 6);
            // long hold while the sender keeps offering, backs the block up
            if (words_checked == 150)
                hold_left = 120;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (ready_stall > 0)
        begin
            ready_stall--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic queue_tick(input bit restart);
        tick_queue.push_back(restart);
        ticks_issued++;
    endtask

    // every tick taken and every write out, then room for a row setup
    task automatic settle();
        do
            @(negedge clk);
        while (ticks_accepted != ticks_issued || pending_writes.size() != 0);
        repeat (24) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BASE_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_BASE_ADDRESS: base_reg = value;
            REG_FRAME_WIDTH:  width_reg = value[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_reg = value[DIM_W-1:0];
            REG_PITCH_BYTES:  pitch_reg = value[PITCH_W-1:0];
            REG_TOP_COLOR:    top_reg = value[RGB_W-1:0];
            REG_BOTTOM_COLOR: bottom_reg = value[RGB_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly tiny frames, now and then zero, oversized or tall
    function automatic logic [BASE_W-1:0] pick_dim(input bit tall);
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return BASE_W'($urandom_range(MAX_DIMENSION, 8191));
            2:       return MAX_DIMENSION;
            3:       return tall ? BASE_W'($urandom_range(7, 300))
                                 : BASE_W'($urandom_range(7, 20));
            default: return BASE_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [BASE_W-1:0] pick_value(input logic [CFG_INDEX_W-1:0] idx);
        case (idx)
            REG_BASE_ADDRESS:
                case ($urandom_range(0, 7))
                    0:       return 0;
                    1:       return '1;
                    default: return BASE_W'({$urandom, $urandom});
                endcase
            REG_FRAME_WIDTH:  return pick_dim(1'b0);
            REG_FRAME_HEIGHT: return pick_dim(1'b1);
            REG_PITCH_BYTES:
                case ($urandom_range(0, 5))
                    0:       return 0;
                    1:       return 32767;
                    default: return BASE_W'($urandom_range(0, 32767));
                endcase
            default:          return BASE_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    initial
    begin
        int unsigned random_items;
        int unsigned pixels;
        int unsigned n;
        int unsigned split;
        bit          r;
        logic [CFG_INDEX_W-1:0] idx;

        base_reg = 0;
        width_reg = 0;
        height_reg = 0;
        pitch_reg = 0;
        top_reg = TOP_COLOR_RESET;
        bottom_reg = BOT_COLOR_RESET;
        walk_col = 0;
        walk_row = 0;
        walk_offset = 0;
        walk_rgb = 0;
        walk_active = 1'b0;
        ticks_issued = 0;
        ticks_accepted = 0;
        words_checked = 0;
        mismatches = 0;
        tick_gap = 0;
        ready_stall = 0;
        hold_left = 0;
        tick_taken = 1'b0;
        word_taken = 1'b0;
        calm = 1'b0;
        random_items = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed ---

        // registers straight out of reset disable drawing: idle advance, dead restart
        queue_tick(1'b0);
        queue_tick(1'b1);
        settle();

        write_reg(REG_BASE_ADDRESS, 48'h1000);
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 2);
        write_reg(REG_PITCH_BYTES, 16);
        write_reg(REG_TOP_COLOR, 24'hFFFFFF);
        write_reg(REG_BOTTOM_COLOR, 0);
        // whole 3x2 frame and one tick past its end
        queue_tick(1'b1);
        repeat (6) queue_tick(1'b0);
        // restart in the middle of a frame
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b0);
        settle();

        // colour change mid-frame shows up from the next row on
        write_reg(REG_TOP_COLOR, 0);
        queue_tick(1'b0);
        queue_tick(1'b0);
        settle();
        // narrowing the width behind the walker ends the frame silently
        write_reg(REG_FRAME_WIDTH, 1);
        queue_tick(1'b0);
        settle();

        // zero width, zero height and zero base each disable a restart
        write_reg(REG_FRAME_WIDTH, 0);
        queue_tick(1'b1);
        settle();
        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 0);
        queue_tick(1'b1);
        settle();
        write_reg(REG_FRAME_HEIGHT, 1);
        write_reg(REG_BASE_ADDRESS, 0);
        queue_tick(1'b1);
        settle();

        // top of the address range, widest pitch, oversized height one pixel wide
        write_reg(REG_BASE_ADDRESS, '1);
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 8191);
        write_reg(REG_PITCH_BYTES, 32767);
        write_reg(REG_BOTTOM_COLOR, 24'hFFFFFF);
        queue_tick(1'b1);
        repeat (5) queue_tick(1'b0);
        settle();
        // base cleared mid-frame stops the walk
        write_reg(REG_BASE_ADDRESS, 0);
        queue_tick(1'b0);
        settle();

        // single pixel frame, last on the first word
        write_reg(REG_BASE_ADDRESS, 4);
        write_reg(REG_FRAME_HEIGHT, 1);
        write_reg(REG_PITCH_BYTES, 0);
        queue_tick(1'b1);
        queue_tick(1'b0);
        settle();

        // long stretch of an oversized-width row; the long output hold lands in here
        write_reg(REG_FRAME_WIDTH, 8191);
        write_reg(REG_PITCH_BYTES, BASE_W'($urandom_range(0, 32767)));
        queue_tick(1'b1);
        repeat (199) queue_tick(1'b0);
        settle();

        // --- random frames ---

        while (random_items < 220)
        begin
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 6; i++)
                if ($urandom_range(0, 1))
                    write_reg(CFG_INDEX_W'(i), pick_value(CFG_INDEX_W'(i)));

            pixels = clamp_dim(width_reg) * clamp_dim(height_reg);
            if (pixels == 0 || base_reg == 0)
                n = $urandom_range(1, 3);
            else if (pixels <= 320)
                n = pixels + $urandom_range(0, 2);   // a few ticks past the end
            else
                n = $urandom_range(1, 40);
            // sometimes stop midway, settle and change one register live
            split = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n;

            for (int i = 0; i < n; i++)
            begin
                if (i == split)
                begin
                    settle();
                    idx = CFG_INDEX_W'($urandom_range(0, 5));
                    write_reg(idx, pick_value(idx));
                end
                r = (i == 0);
                // stray restarts and dropped restarts
                if ($urandom_range(0, 11) == 0)
                    r = 1'($urandom_range(0, 1));
                queue_tick(r);
            end
            random_items += n;
            settle();
        end

        settle();
        if (mismatches == 0)
            $display("vertical_gradient_fill regression: pass");
        else
            $display("vertical_gradient_fill regression: fail");
        $finish;
    end

endmodule

### files.f
hw/rtl/vgf_pkg.sv
hw/rtl/vgf_row_unit.sv
hw/rtl/vertical_gradient_fill.sv
tb/testbench.sv
